FILE: sv/tun_pkg.sv
// ============================================================================
// tun_pkg
// Shared constants and types for the triangle unit normal block.
// ============================================================================
package tun_pkg;

  // Number of vector components.
  localparam int LANES  = 3;
  // Width of a cross-product magnitude after normalization, below 2^30.
  localparam int NORM_W = 30;
  // Group width used by the leading-one search.
  localparam int GRP_W  = 8;
  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 4;

  // Per-item sideband carried along the back pipeline.
  typedef struct packed {
    logic [LANES-1:0][NORM_W-1:0] mag;
    logic [LANES-1:0]             neg;
    logic                         deg;
  } side_t;

endpackage

FILE: sv/tun_front.sv
// ============================================================================
// tun_front
// Accepts vertex triples, forms edge vectors and cross-product terms.
// ============================================================================
module tun_front #(
  parameter int CW = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [9*CW-1:0]                         in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [3*(2*((CW+1 > 31) ? 31 : CW+1)+1)-1:0] out_data
);
  import tun_pkg::*;

  localparam int EW = (CW + 1 > 31) ? 31 : CW + 1;
  localparam int PS = (CW + 1 > 31) ? CW - 30 : 0;
  localparam int RW = 2 * EW + 1;

  // Edge difference with magnitude pre-shift for very wide coordinates.
  function automatic logic signed [EW-1:0] edge_f(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b);
    logic [CW:0] d;
    logic [CW:0] m;
    logic [CW:0] ms;
    d  = {a[CW-1], a} - {b[CW-1], b};
    m  = d[CW] ? (~d + 1'b1) : d;
    ms = m >> PS;
    edge_f = d[CW] ? EW'(~ms + 1'b1) : EW'(ms);
  endfunction

  logic                 v1, v2, adv;
  logic signed [EW-1:0] p [LANES];
  logic signed [EW-1:0] q [LANES];
  logic signed [2*EW-1:0] prod [2*LANES];

  assign adv      = !v2 || out_ready;
  assign in_ready = adv;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        p[i] <= edge_f(in_data[i*CW +: CW], in_data[(3+i)*CW +: CW]);
        q[i] <= edge_f(in_data[(6+i)*CW +: CW], in_data[(3+i)*CW +: CW]);
      end
      prod[0] <= p[1] * q[2];
      prod[1] <= p[2] * q[1];
      prod[2] <= p[2] * q[0];
      prod[3] <= p[0] * q[2];
      prod[4] <= p[0] * q[1];
      prod[5] <= p[1] * q[0];
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_data[i*RW +: RW] = RW'(prod[2*i]) - RW'(prod[2*i+1]);
    end
  end

endmodule

FILE: sv/tun_queue.sv
// ============================================================================
// tun_queue
// Short register queue that decouples the front and back parts.
// ============================================================================
module tun_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import tun_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  logic [W-1:0] mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          push, pop;

  assign in_ready  = count != (AW+1)'(QDEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(QDEPTH)) else $error("queue count above depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count lost a push");
  a_cnt_dn: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("queue count lost a pop");
`endif

endmodule

FILE: sv/tun_back.sv
// ============================================================================
// tun_back
// Normalizes the cross product, takes its length and divides it out.
// ============================================================================
module tun_back #(
  parameter int CW = 16,
  parameter int NW = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [3*(2*((CW+1 > 31) ? 31 : CW+1)+1)-1:0] in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [3*NW-1:0]                         out_data,
  output logic                                    out_deg
);
  import tun_pkg::*;

  localparam int EW   = (CW + 1 > 31) ? 31 : CW + 1;
  localparam int RW   = 2 * EW + 1;
  localparam int MW   = 2 * EW;
  localparam int NG   = (MW + GRP_W - 1) / GRP_W;
  localparam int PW   = $clog2(NG * GRP_W);
  localparam int IW   = $clog2(GRP_W);
  localparam int FB   = NW - 2;
  localparam int SQ   = 31;
  localparam int SW   = 62;
  localparam int LW   = 31;
  localparam int DW   = LW + FB;
  localparam int DV   = FB + 1;
  localparam int NS   = 6 + SQ + 1 + DV;

  logic          adv;
  logic [NS-1:0] vld;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NS-2:0], in_valid};
      out_valid <= vld[NS-1];
    end
  end

  // Stage 0: magnitudes, signs, zero test and OR of magnitudes.
  logic [MW-1:0]    mag0 [LANES];
  logic [MW-1:0]    mag1 [LANES];
  logic [MW-1:0]    mag2 [LANES];
  logic [LANES-1:0] neg0, neg1, neg2;
  logic             deg0, deg1, deg2;
  logic [NG*GRP_W-1:0] orw0;
  logic [NG-1:0]    nz1;
  logic [IW-1:0]    idx1 [NG];
  logic [PW-1:0]    pos2;

  always_ff @(posedge clk) begin
    if (adv) begin
      logic [RW-1:0] r;
      logic [MW-1:0] m;
      logic [NG*GRP_W-1:0] o;
      logic z;
      o = '0;
      z = 1'b1;
      for (int i = 0; i < LANES; i++) begin
        r = in_data[i*RW +: RW];
        m = r[RW-1] ? MW'(~r + 1'b1) : MW'(r);
        mag0[i] <= m;
        neg0[i] <= r[RW-1];
        o = o | (NG*GRP_W)'(m);
        z = z && (r == '0);
      end
      orw0 <= o;
      deg0 <= z;
    end
  end

  // Stage 1: leading one within each byte group.
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [GRP_W-1:0] g;
      logic [IW-1:0] ix;
      for (int k = 0; k < NG; k++) begin
        g  = orw0[k*GRP_W +: GRP_W];
        ix = '0;
        for (int b = 0; b < GRP_W; b++) begin
          if (g[b]) ix = IW'(b);
        end
        nz1[k]  <= |g;
        idx1[k] <= ix;
      end
      mag1 <= mag0;
      neg1 <= neg0;
      deg1 <= deg0;
    end
  end

  // Stage 2: highest nonzero group gives the leading-one position.
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [PW-1:0] ps;
      ps = '0;
      for (int k = 0; k < NG; k++) begin
        if (nz1[k]) ps = PW'(k * GRP_W) + PW'(idx1[k]);
      end
      pos2 <= ps;
      mag2 <= mag1;
      neg2 <= neg1;
      deg2 <= deg1;
    end
  end

  // Stage 3: common shift so the largest magnitude lands in [2^29, 2^30).
  side_t side3, side4, side5;

  always_ff @(posedge clk) begin
    if (adv) begin
      logic [MW+NORM_W-1:0] wide;
      for (int i = 0; i < LANES; i++) begin
        wide = {mag2[i], NORM_W'(0)} >> ((PW+1)'(pos2) + 1'b1);
        side3.mag[i] <= wide[NORM_W-1:0];
      end
      side3.neg <= neg2;
      side3.deg <= deg2;
    end
  end

  // Stages 4 and 5: squares, then their sum.
  logic [2*NORM_W-1:0] sq4 [LANES];
  logic [SW-1:0]       sum5;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        sq4[i] <= side3.mag[i] * side3.mag[i];
      end
      side4 <= side3;
      sum5  <= SW'(sq4[0]) + SW'(sq4[1]) + SW'(sq4[2]);
      side5 <= side4;
    end
  end

  // Square root: one result bit per stage.
  logic [SW-1:0] ss [SQ];
  logic [SW-1:0] rr [SQ];
  side_t         side_s [SQ];
  logic [SW-1:0] ss_n [SQ];
  logic [SW-1:0] rr_n [SQ];

  always_comb begin
    logic [SW-1:0] s_in, r_in, bt;
    for (int st = 0; st < SQ; st++) begin
      s_in = (st == 0) ? sum5 : ss[(st == 0) ? 0 : st-1];
      r_in = (st == 0) ? '0   : rr[(st == 0) ? 0 : st-1];
      bt   = SW'(1) << (2 * (SQ - 1 - st));
      if (s_in >= r_in + bt) begin
        ss_n[st] = s_in - (r_in + bt);
        rr_n[st] = (r_in >> 1) + bt;
      end else begin
        ss_n[st] = s_in;
        rr_n[st] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int st = 0; st < SQ; st++) begin
        ss[st]     <= ss_n[st];
        rr[st]     <= rr_n[st];
        side_s[st] <= (st == 0) ? side5 : side_s[(st == 0) ? 0 : st-1];
      end
    end
  end

  // Numerator stage: scaled magnitude plus half the length.
  logic [DW-1:0] num [LANES];
  logic [LW-1:0] len_n;
  side_t         side_n;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        num[i] <= (DW'(side_s[SQ-1].mag[i]) << FB) + DW'(rr[SQ-1][LW-1:1]);
      end
      len_n  <= rr[SQ-1][LW-1:0];
      side_n <= side_s[SQ-1];
    end
  end

  // Restoring division, one quotient bit per stage for each lane.
  logic [DW-1:0] rem   [DV][LANES];
  logic [DV-1:0] quo   [DV][LANES];
  logic [LW-1:0] len_d [DV];
  side_t         side_d [DV];
  logic [DW-1:0] rem_n [DV][LANES];
  logic [DV-1:0] quo_n [DV][LANES];

  always_comb begin
    logic [DW-1:0] r_in, dv;
    logic [DV-1:0] q_in;
    for (int j = 0; j < DV; j++) begin
      dv = DW'((j == 0) ? len_n : len_d[(j == 0) ? 0 : j-1]) << (FB - j);
      for (int i = 0; i < LANES; i++) begin
        r_in = (j == 0) ? num[i] : rem[(j == 0) ? 0 : j-1][i];
        q_in = (j == 0) ? '0 : quo[(j == 0) ? 0 : j-1][i];
        if (r_in >= dv) begin
          rem_n[j][i] = r_in - dv;
          quo_n[j][i] = q_in | (DV'(1) << (FB - j));
        end else begin
          rem_n[j][i] = r_in;
          quo_n[j][i] = q_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DV; j++) begin
        rem[j]    <= rem_n[j];
        quo[j]    <= quo_n[j];
        len_d[j]  <= (j == 0) ? len_n : len_d[(j == 0) ? 0 : j-1];
        side_d[j] <= (j == 0) ? side_n : side_d[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Output register: apply signs, force zero for a degenerate face.
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [NW-1:0] v;
      for (int i = 0; i < LANES; i++) begin
        v = NW'(quo[DV-1][i]);
        if (side_d[DV-1].deg) out_data[i*NW +: NW] <= '0;
        else if (side_d[DV-1].neg[i]) out_data[i*NW +: NW] <= ~v + 1'b1;
        else out_data[i*NW +: NW] <= v;
      end
      out_deg <= side_d[DV-1].deg;
    end
  end

endmodule

FILE: sv/triangle_unit_normal.sv
// ============================================================================
// triangle_unit_normal
// Unit face normal of a triangle from its three vertices.
// ============================================================================
//
//  channel   dir  tdata                              tuser
//  s_*       in   a_x a_y a_z b_x b_y b_z c_x c_y c_z  -
//  m_*       out  n_x n_y n_z                         degenerate
//
// One transaction is accepted per cycle and one result leaves per cycle when
// neither side stalls. An item passes the front registers, a queue entry and
// the back stages, the bulk of which are the bit-per-stage square root and
// divider pipelines; the rest normalize, square, sum and form the numerator.
// The front part stalls only when the queue is full; the back part stalls as
// a whole when the output register holds a result that is not taken.
// Reset clears the valid bits, queue pointers and count, not the data.
//
module triangle_unit_normal #(
  parameter int COORD_WIDTH  = 16,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  // Fields from bit 0 up: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z.
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0 up: n_x, n_y, n_z.
  output logic [((3*NORMAL_WIDTH+7)/8)*8-1:0] m_tdata,
  // Field: degenerate.
  output logic [0:0]                          m_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready
);

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = NORMAL_WIDTH;
  localparam int EW    = (CW + 1 > 31) ? 31 : CW + 1;
  localparam int RW    = 2 * EW + 1;
  localparam int OUT_W = ((3 * NW + 7) / 8) * 8;

  logic            f_valid, f_ready;
  logic [3*RW-1:0] f_data;
  logic            b_valid, b_ready;
  logic [3*RW-1:0] b_data;
  logic [3*NW-1:0] n_data;

  // Front: edges and cross-product terms.
  tun_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata[9*CW-1:0]),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_data (f_data)
  );

  // Queue holding finished cross products for the back part.
  tun_queue #(.W(3*RW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  (f_data),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_data (b_data)
  );

  // Back: normalization, length, division and output register.
  tun_back #(.CW(CW), .NW(NW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .in_data  (b_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (n_data),
    .out_deg  (m_tuser[0])
  );

  assign m_tdata = OUT_W'(n_data);

`ifndef SYNTH
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> n_data == '0) else $error("degenerate face with nonzero normal");
  a_norm_nz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> n_data != '0) else $error("zero normal without degenerate flag");
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result valid right after reset");
`endif

endmodule
